// ----- rtl/scpl_pkg.sv -----
// Shared types and constants for the sphere chunk point locator.
// No dependencies.
package scpl_pkg;
  localparam int MaxLevelDefault = 3;
  localparam int CoordW = 16;
  localparam int SlotW = 9;
  localparam int NumSlots = 512;
  localparam logic [1:0] LevelReset = 2'd2;
  localparam logic ModeLoad = 1'b0;
  localparam logic ModeQuery = 1'b1;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic                 mode;
    logic [SlotW-1:0]     slot;
    logic [1:0]           corner_sel;
    coord_t               coord_x;
    coord_t               coord_y;
    coord_t               coord_z;
  } in_beat_t;

  typedef struct packed {
    logic [SlotW-1:0] chunk_index;
    logic [3:0]       chunk_row;
    logic [5:0]       chunk_col;
    logic             changed;
    logic             missed;
  } out_beat_t;

  // octant to column block map
  function automatic logic [1:0] oct_map(input logic [2:0] q);
    logic [1:0] r;
    begin
      unique case (q[1:0])
        2'd0: r = 2'd0;
        2'd1: r = 2'd1;
        2'd2: r = 2'd3;
        default: r = 2'd2;
      endcase
      return r;
    end
  endfunction
endpackage

// ----- rtl/scpl_if.sv -----
// Valid/ready channel interfaces for input and result beats.
// Depends on scpl_pkg.
interface scpl_in_if import scpl_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scpl_out_if import scpl_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/sphere_chunk_point_locator.sv -----
// Sphere chunk point locator: corner store, search sequencer, row/column.
// Depends on scpl_pkg, scpl_if, scpl_test_unit.
// Query: per chunk tested, 3 corner reads, a start and the 22 test steps of the shared serial
// test unit; up to 1 + 4^level chunks.
// Result beat held in an output register until taken; the next beat is accepted meanwhile.
// Reset (async, active low): current chunk 0, level 2; corner store unset.
module sphere_chunk_point_locator import scpl_pkg::*; #(
  parameter int MaxLevel = MaxLevelDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  scpl_in_if.sink    in_i,
  scpl_out_if.source out_o
);
  typedef enum logic [4:0] {
    StIdle = 5'b00001, StRead = 5'b00010, StTest = 5'b00100,
    StWait = 5'b01000, StOut = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] level_q;
  logic [SlotW-1:0] cur_q, cur_d, idx_q, idx_d, last_q, last_d;
  logic search_q, search_d;
  out_beat_t res_q, res_d;
  out_beat_t pend_q, pend_d;
  logic ovalid_q, ovalid_d;
  coord_t p_q [3];
  coord_t mem [3*NumSlots][3];
  coord_t cr [3][3];
  logic [1:0] rd_k_q;
  logic [SlotW-1:0] rd_slot;
  logic t_start, t_done, t_hit;
  logic [1:0] lv;

  assign lv = (32'(level_q) < MaxLevel) ? level_q : 2'(MaxLevel);

  // store address: slot * 3 + corner
  function automatic logic [10:0] st_addr(input logic [SlotW-1:0] s, input logic [1:0] k);
    return 11'({s, 1'b0}) + 11'(s) + 11'(k);
  endfunction

  // corner store: three reads of one corner a cycle
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready && in_i.data.mode == ModeLoad &&
        in_i.data.corner_sel != 2'd3) begin
      mem[st_addr(in_i.data.slot, in_i.data.corner_sel)] <=
        '{in_i.data.coord_x, in_i.data.coord_y, in_i.data.coord_z};
    end
    if (state_q == StRead) cr[rd_k_q] <= mem[st_addr(rd_slot, rd_k_q)];
  end
  assign rd_slot = search_q ? idx_q : cur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_k_q <= '0;
    else if (state_q == StRead) rd_k_q <= (rd_k_q == 2'd2) ? 2'd0 : rd_k_q + 2'd1;
  end

  scpl_test_unit u_test (
    .clk_i, .rst_ni, .start_i(t_start), .c0_i(cr[0]), .c1_i(cr[1]), .c2_i(cr[2]),
    .p_i(p_q), .done_o(t_done), .hit_o(t_hit)
  );
  assign t_start = (state_q == StTest);

  // row/column of the final chunk, sqrt by short count over at most 8 rows
  function automatic out_beat_t mk_res(input logic [SlotW-1:0] i, input logic [1:0] l,
                                       input logic ch, input logic ms);
    out_beat_t r;
    logic [5:0] m, r0, col;
    logic [2:0] q;
    logic [SlotW-1:0] msk;
    begin
      msk = SlotW'((1 << (2 * l)) - 1);
      m = 6'(i & msk);
      q = 3'(i >> (2 * l));
      r0 = '0;
      for (int k = 1; k < 8; k++) if (12'(k * k) <= 12'(m)) r0 = 6'(k);
      col = 6'(m - 6'(r0 * r0) + 6'(oct_map(q) * (2 * r0 + 1)));
      r.chunk_index = i;
      r.chunk_row = q[2] ? 4'((2 << l) - 1 - r0) : 4'(r0);
      r.chunk_col = col;
      r.changed = ch;
      r.missed = ms;
      return r;
    end
  endfunction

  always_comb begin
    state_d = state_q;
    cur_d = cur_q;
    idx_d = idx_q;
    last_d = last_q;
    search_d = search_q;
    res_d = res_q;
    pend_d = pend_q;
    ovalid_d = ovalid_q;
    if (out_o.valid && out_o.ready) ovalid_d = 1'b0;
    unique case (state_q)
      StIdle: if (in_i.valid && in_i.data.mode == ModeQuery) begin
        state_d = StRead;
        search_d = 1'b0;
        idx_d = SlotW'({in_i.data.coord_z[15], in_i.data.coord_y[15],
                        in_i.data.coord_x[15]} << (2 * lv));
        last_d = SlotW'(idx_d + SlotW'((1 << (2 * lv)) - 1));
      end
      StRead: if (rd_k_q == 2'd2) state_d = StTest;
      StTest: state_d = StWait;
      StWait: if (t_done) begin
        if (t_hit) begin
          if (search_q) cur_d = idx_q;
          pend_d = mk_res(search_q ? idx_q : cur_q, lv, search_q, 1'b0);
          state_d = StOut;
        end else if (!search_q) begin
          search_d = 1'b1;
          state_d = StRead;
        end else if (idx_q == last_q) begin
          pend_d = mk_res(cur_q, lv, 1'b0, 1'b1);
          state_d = StOut;
        end else begin
          idx_d = idx_q + SlotW'(1);
          state_d = StRead;
        end
      end
      StOut: if (!ovalid_q || out_o.ready) begin
        res_d = pend_q;
        ovalid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_i.ready = (state_q == StIdle);
  assign out_o.valid = ovalid_q;
  assign out_o.data = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cur_q <= '0;
      level_q <= LevelReset;
      ovalid_q <= 1'b0;
      search_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q <= cur_d;
      ovalid_q <= ovalid_d;
      search_q <= search_d;
      if (cfg_we_i) level_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    last_q <= last_d;
    res_q <= res_d;
    pend_q <= pend_d;
    if (in_i.valid && in_i.ready) p_q <= '{in_i.data.coord_x, in_i.data.coord_y,
                                            in_i.data.coord_z};
  end
endmodule

// ----- rtl/scpl_test_unit.sv -----
// Sequenced barycentric containment test with a shared small multiplier and a shared big multiplier.
// Depends on scpl_pkg.
module scpl_test_unit import scpl_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  coord_t c0_i [3],
  input  coord_t c1_i [3],
  input  coord_t c2_i [3],
  input  coord_t p_i [3],
  output logic   done_o,
  output logic   hit_o
);
  // step counter: 0..14 products of dots, 15..20 big products, 21 compare
  logic [4:0] step_q, step_d;
  logic busy_q, busy_d;
  logic [2:0] dsel_q, dsel_d;
  logic [1:0] comp_q, comp_d;
  logic signed [16:0] v0 [3], v1 [3], v2 [3];
  logic signed [34:0] acc_q, acc_d;
  logic signed [30:0] d_q [5];
  logic signed [63:0] den_q, un_q, vn_q;
  logic signed [63:0] den_d, un_d, vn_d;
  logic signed [33:0] prod_s;
  logic signed [61:0] prod_b;
  logic signed [16:0] ma, mb;
  logic signed [30:0] ba, bb;
  logic signed [64:0] uv_sum;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      v0[j] = 17'(c2_i[j]) - 17'(c0_i[j]);
      v1[j] = 17'(c1_i[j]) - 17'(c0_i[j]);
      v2[j] = 17'(p_i[j]) - 17'(c0_i[j]);
    end
  end

  // small multiplier operands: dot select and component from their own counters
  always_comb begin
    unique case (dsel_q)
      3'd0: begin ma = v0[comp_q]; mb = v0[comp_q]; end
      3'd1: begin ma = v0[comp_q]; mb = v1[comp_q]; end
      3'd2: begin ma = v0[comp_q]; mb = v2[comp_q]; end
      3'd3: begin ma = v1[comp_q]; mb = v1[comp_q]; end
      default: begin ma = v1[comp_q]; mb = v2[comp_q]; end
    endcase
  end
  assign prod_s = ma * mb;

  // big products, 31x31 signed
  always_comb begin
    unique case (step_q)
      5'd15: begin ba = d_q[0]; bb = d_q[3]; end
      5'd16: begin ba = d_q[1]; bb = d_q[1]; end
      5'd17: begin ba = d_q[3]; bb = d_q[2]; end
      5'd18: begin ba = d_q[1]; bb = d_q[4]; end
      5'd19: begin ba = d_q[0]; bb = d_q[4]; end
      default: begin ba = d_q[1]; bb = d_q[2]; end
    endcase
  end
  assign prod_b = ba * bb;
  assign uv_sum = 65'(un_q) + 65'(vn_q);

  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    dsel_d = dsel_q;
    comp_d = comp_q;
    acc_d = acc_q;
    den_d = den_q;
    un_d = un_q;
    vn_d = vn_q;
    done_o = 1'b0;
    hit_o = 1'b0;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      step_d = '0;
      dsel_d = '0;
      comp_d = '0;
      acc_d = '0;
    end else if (busy_q) begin
      step_d = step_q + 5'd1;
      if (step_q < 5'd15) begin
        acc_d = (comp_q == 2'd0) ? 35'(prod_s) : acc_q + 35'(prod_s);
        if (comp_q == 2'd2) begin
          comp_d = 2'd0;
          dsel_d = dsel_q + 3'd1;
        end else begin
          comp_d = comp_q + 2'd1;
        end
      end
      unique case (step_q)
        5'd15: den_d = 64'(prod_b);
        5'd16: den_d = den_q - 64'(prod_b);
        5'd17: un_d = 64'(prod_b);
        5'd18: un_d = un_q - 64'(prod_b);
        5'd19: vn_d = 64'(prod_b);
        5'd20: vn_d = vn_q - 64'(prod_b);
        default: ;
      endcase
      if (step_q == 5'd21) begin
        busy_d = 1'b0;
        done_o = 1'b1;
        hit_o = (den_q > 0) && (un_q >= 0) && (vn_q >= 0) && (uv_sum < 65'(den_q));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      dsel_q <= '0;
      comp_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      dsel_q <= dsel_d;
      comp_q <= comp_d;
    end
  end

  // dot results latched in the step after their last term; arithmetic shift floors
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    den_q <= den_d;
    un_q <= un_d;
    vn_q <= vn_d;
    if (busy_q && step_q <= 5'd15 && comp_q == 2'd0 && dsel_q != 3'd0)
      d_q[dsel_q - 3'd1] <= 31'(acc_q >>> 4);
  end
endmodule

// ----- rtl/scpl_checker.sv -----
// Port-level checks for the locator, bound to the top level.
// Depends on scpl_pkg.
module scpl_checker import scpl_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i, input logic in_ready_i,
  input logic out_valid_i, input logic out_ready_i,
  input out_beat_t out_data_i
);
  // a held result beat does not change
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i)) else $error("result changed");
  // a held result beat stays valid
  a_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped");
  // changed and missed never both set
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_data_i.changed && out_data_i.missed)) else $error("flags");
  // a waiting input beat stays offered
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |=> in_valid_i) else $error("input dropped");
  // column stays in range
  a_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.chunk_col < 6'd60) else $error("col range");
endmodule

bind sphere_chunk_point_locator scpl_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i(in_i.valid), .in_ready_i(in_i.ready),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready), .out_data_i(out_o.data)
);
